FILE: sv/m65x_pkg.sv
// Package with the operation codes, sequencer states and shared types of the 6502 subset executor.
`default_nettype none
package m65x_pkg;

   localparam int unsigned AddrWidth = 16;
   localparam logic [7:0] SpReset = 8'hFF;
   localparam logic [7:0] StackPage = 8'h01;
   localparam logic [15:0] VecLo = 16'hFFFE;
   localparam logic [15:0] VecHi = 16'hFFFF;

   localparam logic [7:0] FlagN = 8'h80;
   localparam logic [7:0] FlagB = 8'h10;
   localparam logic [7:0] FlagZ = 8'h02;

   // Operation codes
   localparam logic [5:0] FnLdaImm = 6'd0;
   localparam logic [5:0] FnLastLda = 6'd7;
   localparam logic [5:0] FnLastLdx = 6'd12;
   localparam logic [5:0] FnLastLoad = 6'd17;
   localparam logic [5:0] FnStaAbs = 6'd18;
   localparam logic [5:0] FnLastSta = 6'd24;
   localparam logic [5:0] FnLastStx = 6'd27;
   localparam logic [5:0] FnLastStore = 6'd30;
   localparam logic [5:0] FnTax = 6'd31;
   localparam logic [5:0] FnTay = 6'd32;
   localparam logic [5:0] FnTxa = 6'd33;
   localparam logic [5:0] FnTya = 6'd34;
   localparam logic [5:0] FnPha = 6'd35;
   localparam logic [5:0] FnPla = 6'd36;
   localparam logic [5:0] FnJmpAbs = 6'd37;
   localparam logic [5:0] FnJmpInd = 6'd38;
   localparam logic [5:0] FnJsr = 6'd39;
   localparam logic [5:0] FnRts = 6'd40;
   localparam logic [5:0] FnBeq = 6'd41;
   localparam logic [5:0] FnClc = 6'd42;
   localparam logic [5:0] FnCld = 6'd43;
   localparam logic [5:0] FnCli = 6'd44;
   localparam logic [5:0] FnSec = 6'd46;
   localparam logic [5:0] FnSed = 6'd47;
   localparam logic [5:0] FnSei = 6'd48;
   localparam logic [5:0] FnBrk = 6'd49;
   localparam logic [5:0] FnNop = 6'd50;
   localparam logic [5:0] FnRti = 6'd51;
   localparam logic [5:0] FnHostWr = 6'd52;
   localparam logic [5:0] FnHostRd = 6'd53;

   typedef enum logic [3:0] {
      MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_ABS,
      MODE_ABSX, MODE_ABSY, MODE_INDX, MODE_INDY
   } mode_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_OP1,    // first operand byte arriving
      ST_OP2,    // second operand byte arriving
      ST_PTR1,   // pointer low byte arriving
      ST_PTR2,   // pointer high byte arriving
      ST_DATA,   // load data arriving
      ST_PUSH2,
      ST_PUSH3,
      ST_PULL1,
      ST_PULL2,
      ST_PULL3,
      ST_VEC1,
      ST_VEC2,
      ST_HOSTRD,
      ST_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        en;
      logic        wr;
      logic [15:0] addr;
      logic [7:0]  wdata;
   } mem_req_type;

   typedef struct packed {
      logic [3:0] mode;
      logic [2:0] cyc;
   } decode_type;

   function automatic decode_type load_decode(input logic [4:0] k);
      decode_type d;
      d.mode = 4'(MODE_IMM);
      d.cyc = 3'd2;
      unique case (k)
         5'd0: begin d.mode = 4'(MODE_IMM);  d.cyc = 3'd2; end
         5'd1: begin d.mode = 4'(MODE_ABS);  d.cyc = 3'd4; end
         5'd2: begin d.mode = 4'(MODE_ABSX); d.cyc = 3'd4; end
         5'd3: begin d.mode = 4'(MODE_ABSY); d.cyc = 3'd4; end
         5'd4: begin d.mode = 4'(MODE_ZP);   d.cyc = 3'd3; end
         5'd5: begin d.mode = 4'(MODE_ZPX);  d.cyc = 3'd4; end
         5'd6: begin d.mode = 4'(MODE_INDX); d.cyc = 3'd6; end
         5'd7: begin d.mode = 4'(MODE_INDY); d.cyc = 3'd5; end
         5'd8: begin d.mode = 4'(MODE_IMM);  d.cyc = 3'd2; end
         5'd9: begin d.mode = 4'(MODE_ABS);  d.cyc = 3'd4; end
         5'd10: begin d.mode = 4'(MODE_ABSY); d.cyc = 3'd4; end
         5'd11: begin d.mode = 4'(MODE_ZP);   d.cyc = 3'd3; end
         5'd12: begin d.mode = 4'(MODE_ZPY);  d.cyc = 3'd4; end
         5'd13: begin d.mode = 4'(MODE_IMM);  d.cyc = 3'd2; end
         5'd14: begin d.mode = 4'(MODE_ABS);  d.cyc = 3'd4; end
         5'd15: begin d.mode = 4'(MODE_ABSX); d.cyc = 3'd4; end
         5'd16: begin d.mode = 4'(MODE_ZP);   d.cyc = 3'd3; end
         5'd17: begin d.mode = 4'(MODE_ZPX);  d.cyc = 3'd4; end
         default: begin d.mode = 4'(MODE_IMM); d.cyc = 3'd2; end
      endcase
      return d;
   endfunction

   function automatic decode_type store_decode(input logic [3:0] k);
      decode_type d;
      d.mode = 4'(MODE_ABS);
      d.cyc = 3'd4;
      unique case (k)
         4'd0: begin d.mode = 4'(MODE_ABS);  d.cyc = 3'd4; end
         4'd1: begin d.mode = 4'(MODE_ZP);   d.cyc = 3'd3; end
         4'd2: begin d.mode = 4'(MODE_ZPX);  d.cyc = 3'd4; end
         4'd3: begin d.mode = 4'(MODE_ABSX); d.cyc = 3'd5; end
         4'd4: begin d.mode = 4'(MODE_ABSY); d.cyc = 3'd5; end
         4'd5: begin d.mode = 4'(MODE_INDX); d.cyc = 3'd6; end
         4'd6: begin d.mode = 4'(MODE_INDY); d.cyc = 3'd6; end
         4'd7: begin d.mode = 4'(MODE_ZP);   d.cyc = 3'd3; end
         4'd8: begin d.mode = 4'(MODE_ZPY);  d.cyc = 3'd4; end
         4'd9: begin d.mode = 4'(MODE_ABS);  d.cyc = 3'd4; end
         4'd10: begin d.mode = 4'(MODE_ZP);  d.cyc = 3'd3; end
         4'd11: begin d.mode = 4'(MODE_ZPX); d.cyc = 3'd4; end
         4'd12: begin d.mode = 4'(MODE_ABS); d.cyc = 3'd4; end
         default: begin d.mode = 4'(MODE_ABS); d.cyc = 3'd4; end
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

FILE: sv/m65x_mem.sv
// Single-port synchronous byte memory with a registered read port.
`default_nettype none
module m65x_mem
   import m65x_pkg::*;
(
   input  wire logic              clock,
   input  wire mem_req_type       req,
   output logic [7:0]             rdata
);

   logic [7:0] mem_ff [2**AddrWidth];

   always_ff @(posedge clock) begin
      if (req.en) begin
         if (req.wr) begin
            mem_ff[req.addr] <= req.wdata;
         end else begin
            rdata <= mem_ff[req.addr];
         end
      end
   end

endmodule
`default_nettype wire

FILE: sv/m65x_seq.sv
// Instruction sequencer: register file, addressing and memory access steps.
`default_nettype none
module m65x_seq
   import m65x_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [5:0]  req_func,
   input  wire logic [15:0] req_host_addr,
   input  wire logic [7:0]  req_host_data,
   output mem_req_type      mem_req,
   input  wire logic [7:0]  mem_rdata,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_reg_a,
   output logic [7:0]       rsp_reg_x,
   output logic [7:0]       rsp_reg_y,
   output logic [7:0]       rsp_stack_ptr,
   output logic [15:0]      rsp_prog_counter,
   output logic [7:0]       rsp_status_flags,
   output logic [2:0]       rsp_cycles,
   output logic [7:0]       rsp_read_data
);

   state_type state_ff, state_in;
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, sp_ff, sp_in, p_ff, p_in;
   logic [15:0] pc_ff, pc_in;
   logic [5:0]  func_ff, func_in;
   logic [15:0] haddr_ff, haddr_in;
   logic [7:0]  hdata_ff, hdata_in;
   logic [7:0]  lo_ff, lo_in;
   logic [15:0] ea_ff, ea_in;
   logic [2:0]  cyc_ff, cyc_in;
   logic [7:0]  rd_ff, rd_in;
   logic [3:0]  mode_ff, mode_in;
   logic        is_load_ff, is_load_in;
   logic [7:0]  st_val_ff, st_val_in;

   decode_type ld_dec, st_dec;
   logic [15:0] full16, idx_sum;
   logic [7:0]  idx;
   logic [15:0] br_off, br_tgt;

   assign ld_dec = load_decode(func_ff[4:0]);
   assign st_dec = store_decode(4'(func_ff - FnStaAbs));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         a_ff <= '0; x_ff <= '0; y_ff <= '0;
         sp_ff <= SpReset; pc_ff <= '0; p_ff <= '0;
      end else begin
         state_ff <= state_in;
         a_ff <= a_in; x_ff <= x_in; y_ff <= y_in;
         sp_ff <= sp_in; pc_ff <= pc_in; p_ff <= p_in;
      end
      func_ff <= func_in; haddr_ff <= haddr_in; hdata_ff <= hdata_in;
      lo_ff <= lo_in; ea_ff <= ea_in; cyc_ff <= cyc_in; rd_ff <= rd_in;
      mode_ff <= mode_in; is_load_ff <= is_load_in; st_val_ff <= st_val_in;
   end

   function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] r;
      r = p & ~(FlagN | FlagZ);
      if (v == 8'd0) r = r | FlagZ;
      if (v[7]) r = r | FlagN;
      return r;
   endfunction

   always_comb begin
      state_in = state_ff;
      a_in = a_ff; x_in = x_ff; y_in = y_ff; sp_in = sp_ff; pc_in = pc_ff; p_in = p_ff;
      func_in = func_ff; haddr_in = haddr_ff; hdata_in = hdata_ff;
      lo_in = lo_ff; ea_in = ea_ff; cyc_in = cyc_ff; rd_in = rd_ff;
      mode_in = mode_ff; is_load_in = is_load_ff; st_val_in = st_val_ff;
      mem_req = '0;
      full16 = {mem_rdata, lo_ff};
      idx = (mode_ff == 4'(MODE_ABSX)) ? x_ff : y_ff;
      idx_sum = full16 + {8'd0, idx};
      br_off = {{8{mem_rdata[7]}}, mem_rdata};
      br_tgt = pc_ff + br_off;
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in = req_func; haddr_in = req_host_addr; hdata_in = req_host_data;
               cyc_in = 3'd0; rd_in = 8'd0;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_DONE;
            if (func_ff <= FnLastStore) begin
               is_load_in = (func_ff <= FnLastLoad);
               if (func_ff <= FnLastLoad) begin
                  mode_in = ld_dec.mode; cyc_in = ld_dec.cyc;
               end else begin
                  mode_in = st_dec.mode; cyc_in = st_dec.cyc;
               end
               st_val_in = (func_ff <= FnLastSta) ? a_ff :
                           ((func_ff <= FnLastStx) ? x_ff : y_ff);
               mem_req.en = 1'b1; mem_req.addr = pc_ff;
               pc_in = pc_ff + 16'd1;
               state_in = ST_OP1;
            end else if (func_ff >= FnClc && func_ff <= FnSei) begin
               cyc_in = 3'd2;
               priority case (func_ff)
                  FnClc, FnSec: p_in[0] = (func_ff == FnSec);
                  FnCld, FnSed: p_in[3] = (func_ff == FnSed);
                  FnCli, FnSei: p_in[2] = (func_ff == FnSei);
                  default: p_in[6] = 1'b0;
               endcase
            end else begin
               priority case (func_ff)
                  FnTax: begin x_in = a_ff; p_in = nz(p_ff, a_ff); cyc_in = 3'd2; end
                  FnTay: begin y_in = a_ff; p_in = nz(p_ff, a_ff); cyc_in = 3'd2; end
                  FnTxa: begin a_in = x_ff; p_in = nz(p_ff, x_ff); cyc_in = 3'd2; end
                  FnTya: begin a_in = y_ff; p_in = nz(p_ff, y_ff); cyc_in = 3'd2; end
                  FnPha: begin
                     mem_req = '{en: 1'b1, wr: 1'b1, addr: {StackPage, sp_ff}, wdata: a_ff};
                     sp_in = sp_ff - 8'd1; cyc_in = 3'd3;
                  end
                  FnPla, FnRts, FnRti: begin
                     mem_req.en = 1'b1; mem_req.addr = {StackPage, sp_ff + 8'd1};
                     sp_in = sp_ff + 8'd1;
                     cyc_in = (func_ff == FnPla) ? 3'd4 : 3'd6;
                     state_in = ST_PULL1;
                  end
                  FnJmpAbs, FnJmpInd, FnJsr, FnBeq: begin
                     mem_req.en = 1'b1; mem_req.addr = pc_ff;
                     pc_in = pc_ff + 16'd1;
                     state_in = ST_OP1;
                  end
                  FnBrk: begin
                     mem_req.en = 1'b1; mem_req.addr = VecLo;
                     cyc_in = 3'd7; state_in = ST_VEC1;
                  end
                  FnNop: cyc_in = 3'd2;
                  FnHostWr: begin
                     mem_req = '{en: 1'b1, wr: 1'b1, addr: haddr_ff, wdata: hdata_ff};
                  end
                  FnHostRd: begin
                     mem_req.en = 1'b1; mem_req.addr = haddr_ff;
                     state_in = ST_HOSTRD;
                  end
                  default: ;
               endcase
            end
         end
         ST_OP1: begin
            lo_in = mem_rdata;
            state_in = ST_DONE;
            if (func_ff == FnBeq) begin
               cyc_in = 3'd2;
               if ((p_ff & FlagZ) != 8'd0) begin
                  pc_in = br_tgt;
                  cyc_in = (br_tgt[15:8] != pc_ff[15:8]) ? 3'd4 : 3'd3;
               end
            end else if (func_ff > FnLastStore) begin
               mem_req.en = 1'b1; mem_req.addr = pc_ff;
               pc_in = pc_ff + 16'd1; state_in = ST_OP2;
            end else begin
               unique case (mode_ff)
                  4'(MODE_IMM): begin
                     ea_in = pc_ff - 16'd1;
                     mem_req.en = 1'b1; mem_req.addr = pc_ff - 16'd1;
                     state_in = ST_DATA;
                  end
                  4'(MODE_ZP), 4'(MODE_ZPX), 4'(MODE_ZPY): begin
                     ea_in = {8'd0, mem_rdata + ((mode_ff == 4'(MODE_ZPX)) ? x_ff :
                              (mode_ff == 4'(MODE_ZPY)) ? y_ff : 8'd0)};
                     state_in = ST_DATA;
                     mem_req.en = 1'b1; mem_req.addr = ea_in; mem_req.wr = !is_load_ff;
                     mem_req.wdata = st_val_ff;
                     if (!is_load_ff) state_in = ST_DONE;
                  end
                  4'(MODE_INDX), 4'(MODE_INDY): begin
                     lo_in = mem_rdata + ((mode_ff == 4'(MODE_INDX)) ? x_ff : 8'd0);
                     mem_req.en = 1'b1; mem_req.addr = {8'd0, lo_in};
                     state_in = ST_PTR1;
                  end
                  default: begin
                     mem_req.en = 1'b1; mem_req.addr = pc_ff;
                     pc_in = pc_ff + 16'd1; state_in = ST_OP2;
                  end
               endcase
            end
         end
         ST_OP2: begin
            state_in = ST_DONE;
            priority case (func_ff)
               FnJmpAbs: begin pc_in = full16; cyc_in = 3'd3; end
               FnJmpInd: begin
                  ea_in = full16; cyc_in = 3'd5;
                  mem_req.en = 1'b1; mem_req.addr = full16;
                  state_in = ST_VEC1;
               end
               FnJsr: begin
                  ea_in = full16; cyc_in = 3'd6;
                  mem_req = '{en: 1'b1, wr: 1'b1, addr: {StackPage, sp_ff}, wdata: pc_ff[15:8]};
                  sp_in = sp_ff - 8'd1; state_in = ST_PUSH2;
               end
               default: begin
                  if (mode_ff == 4'(MODE_ABS)) begin
                     ea_in = full16;
                  end else begin
                     ea_in = idx_sum;
                     if (is_load_ff && idx_sum[15:8] != mem_rdata) cyc_in = cyc_ff + 3'd1;
                  end
                  mem_req.en = 1'b1; mem_req.addr = ea_in; mem_req.wr = !is_load_ff;
                  mem_req.wdata = st_val_ff;
                  state_in = is_load_ff ? ST_DATA : ST_DONE;
               end
            endcase
         end
         ST_PTR1: begin
            ea_in = {8'd0, mem_rdata};
            mem_req.en = 1'b1; mem_req.addr = {8'd0, lo_ff + 8'd1};
            state_in = ST_PTR2;
         end
         ST_PTR2: begin
            if (mode_ff == 4'(MODE_INDX)) begin
               ea_in = {mem_rdata, ea_ff[7:0]};
            end else begin
               ea_in = {mem_rdata, ea_ff[7:0]} + {8'd0, y_ff};
               if (is_load_ff && ea_in[15:8] != mem_rdata) cyc_in = cyc_ff + 3'd1;
            end
            mem_req.en = 1'b1; mem_req.addr = ea_in; mem_req.wr = !is_load_ff;
            mem_req.wdata = st_val_ff;
            state_in = is_load_ff ? ST_DATA : ST_DONE;
         end
         ST_DATA: begin
            p_in = nz(p_ff, mem_rdata);
            if (func_ff <= FnLastLda) a_in = mem_rdata;
            else if (func_ff <= FnLastLdx) x_in = mem_rdata;
            else y_in = mem_rdata;
            state_in = ST_DONE;
         end
         ST_PUSH2: begin
            mem_req = '{en: 1'b1, wr: 1'b1, addr: {StackPage, sp_ff}, wdata: pc_ff[7:0]};
            sp_in = sp_ff - 8'd1;
            if (func_ff == FnBrk) begin
               state_in = ST_PUSH3;
            end else begin
               pc_in = ea_ff; state_in = ST_DONE;
            end
         end
         ST_PUSH3: begin
            mem_req = '{en: 1'b1, wr: 1'b1, addr: {StackPage, sp_ff}, wdata: p_ff};
            sp_in = sp_ff - 8'd1;
            pc_in = ea_ff; p_in = p_ff | FlagB;
            state_in = ST_DONE;
         end
         ST_VEC1: begin
            lo_in = mem_rdata;
            mem_req.en = 1'b1;
            // Indirect jump keeps the high-byte fetch inside the vector's page.
            mem_req.addr = (func_ff == FnBrk) ? VecHi : {ea_ff[15:8], ea_ff[7:0] + 8'd1};
            state_in = ST_VEC2;
         end
         ST_VEC2: begin
            if (func_ff == FnBrk) begin
               ea_in = full16;
               mem_req = '{en: 1'b1, wr: 1'b1, addr: {StackPage, sp_ff}, wdata: pc_ff[15:8]};
               sp_in = sp_ff - 8'd1; state_in = ST_PUSH2;
            end else begin
               pc_in = full16; state_in = ST_DONE;
            end
         end
         ST_PULL1: begin
            state_in = ST_DONE;
            if (func_ff == FnPla) begin
               a_in = mem_rdata; p_in = nz(p_ff, mem_rdata);
            end else begin
               if (func_ff == FnRti) p_in = mem_rdata;
               else lo_in = mem_rdata;
               mem_req.en = 1'b1; mem_req.addr = {StackPage, sp_ff + 8'd1};
               sp_in = sp_ff + 8'd1;
               state_in = (func_ff == FnRti) ? ST_PULL3 : ST_PULL2;
            end
         end
         ST_PULL3: begin
            lo_in = mem_rdata;
            mem_req.en = 1'b1; mem_req.addr = {StackPage, sp_ff + 8'd1};
            sp_in = sp_ff + 8'd1;
            state_in = ST_PULL2;
         end
         ST_PULL2: begin
            pc_in = full16; state_in = ST_DONE;
         end
         ST_HOSTRD: begin
            rd_in = mem_rdata; state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_reg_a = a_ff;
   assign rsp_reg_x = x_ff;
   assign rsp_reg_y = y_ff;
   assign rsp_stack_ptr = sp_ff;
   assign rsp_prog_counter = pc_ff;
   assign rsp_status_flags = p_ff;
   assign rsp_cycles = cyc_ff;
   assign rsp_read_data = rd_ff;

   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accepted item while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(pc_ff)))
      else $error("result changed while stalled");
   a_no_mem_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> !mem_req.en) else $error("memory access while reporting");

endmodule
`default_nettype wire

FILE: sv/mos6502_subset_executor_top.sv
// Top level of the 6502 subset executor: sequencer plus 64 KiB program memory.
//
// One item on the req_ channel carries an operation code and, for host memory
// accesses, an address and a data byte. Each item yields exactly one result
// item on the rsp_ channel with the register file, flags, the instruction's
// nominal cycle count and, for a host read, the byte read.
// An item passes, from acceptance until its result can be taken, through a
// decode state, one state for each further step on the single-port memory
// (up to four for BRK, JMP indirect and the indirect loads), a settle state
// and the result state. One item is in flight at a time, req_stall stays high
// from acceptance until the result has been taken, and the sequencer then
// returns to its idle state, in which the next item is accepted.
// The result stays on rsp_ with rsp_valid high for as long as rsp_stall is
// high. Reset clears A, X, Y, PC and the flags and sets SP to 0xFF; memory
// contents are not cleared and must be written before they are read.
`default_nettype none
module mos6502_subset_executor_top
   import m65x_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [5:0]  req_func,
   input  wire logic [15:0] req_host_addr,
   input  wire logic [7:0]  req_host_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_reg_a,
   output logic [7:0]       rsp_reg_x,
   output logic [7:0]       rsp_reg_y,
   output logic [7:0]       rsp_stack_ptr,
   output logic [15:0]      rsp_prog_counter,
   output logic [7:0]       rsp_status_flags,
   output logic [2:0]       rsp_cycles,
   output logic [7:0]       rsp_read_data
);

   mem_req_type mem_req;
   logic [7:0]  mem_rdata;

   m65x_seq u_seq (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_host_addr, .req_host_data,
      .mem_req, .mem_rdata, .rsp_valid, .rsp_stall, .rsp_reg_a, .rsp_reg_x, .rsp_reg_y,
      .rsp_stack_ptr, .rsp_prog_counter, .rsp_status_flags, .rsp_cycles, .rsp_read_data
   );

   m65x_mem u_mem (
      .clock, .req(mem_req), .rdata(mem_rdata)
   );

endmodule
`default_nettype wire

FILE: verif/mos6502_subset_executor_top_test.sv
// Self-checking testbench for the 6502 subset executor with its own instruction-level predictor.
`default_nettype none
module mos6502_subset_executor_top_test
   import m65x_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RandomItems = 1700;
   localparam int unsigned CycleLimit = 1000000;
   localparam int unsigned DrainCycles = 20;

   typedef enum logic [5:0] {
      OP_LDA_IMM, OP_LDA_ABS, OP_LDA_ABSX, OP_LDA_ABSY, OP_LDA_ZP, OP_LDA_ZPX,
      OP_LDA_INDX, OP_LDA_INDY,
      OP_LDX_IMM, OP_LDX_ABS, OP_LDX_ABSY, OP_LDX_ZP, OP_LDX_ZPY,
      OP_LDY_IMM, OP_LDY_ABS, OP_LDY_ABSX, OP_LDY_ZP, OP_LDY_ZPX,
      OP_STA_ABS, OP_STA_ZP, OP_STA_ZPX, OP_STA_ABSX, OP_STA_ABSY, OP_STA_INDX,
      OP_STA_INDY,
      OP_STX_ZP, OP_STX_ZPY, OP_STX_ABS, OP_STY_ZP, OP_STY_ZPX, OP_STY_ABS,
      OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_PHA, OP_PLA,
      OP_JMP_ABS, OP_JMP_IND, OP_JSR, OP_RTS, OP_BEQ,
      OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_SEC, OP_SED, OP_SEI,
      OP_BRK, OP_NOP, OP_RTI, OP_HOST_WR, OP_HOST_RD,
      OP_UNUSED_FIRST, OP_UNUSED_LAST = 6'd63
   } op_code_type;

   typedef struct packed {
      logic [5:0]  func;
      logic [15:0] host_addr;
      logic [7:0]  host_data;
   } op_item_type;

   typedef struct packed {
      logic [7:0]  reg_a;
      logic [7:0]  reg_x;
      logic [7:0]  reg_y;
      logic [7:0]  stack_ptr;
      logic [15:0] prog_counter;
      logic [7:0]  status_flags;
      logic [2:0]  cycles;
      logic [7:0]  read_data;
   } cpu_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [5:0] req_func = '0;
   logic [15:0] req_host_addr = '0;
   logic [7:0] req_host_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_reg_a, rsp_reg_x, rsp_reg_y, rsp_stack_ptr, rsp_status_flags;
   logic [7:0] rsp_read_data;
   logic [15:0] rsp_prog_counter;
   logic [2:0] rsp_cycles;

   mos6502_subset_executor_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_host_addr(req_host_addr), .req_host_data(req_host_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_reg_a(rsp_reg_a), .rsp_reg_x(rsp_reg_x), .rsp_reg_y(rsp_reg_y),
      .rsp_stack_ptr(rsp_stack_ptr), .rsp_prog_counter(rsp_prog_counter),
      .rsp_status_flags(rsp_status_flags), .rsp_cycles(rsp_cycles),
      .rsp_read_data(rsp_read_data)
   );

   always #2 clock = ~clock;

   // Predicted processor state and memory image.
   logic [7:0] mem_image [0:65535];
   bit mem_known [0:65535];
   logic [7:0] acc, xr, yr, sp, flags;
   logic [15:0] pc;
   logic [2:0] op_cyc;
   bit probe_missed;
   logic [15:0] probe_addr;
   bit committing;

   mode_type ld_mode [0:17] = '{MODE_IMM, MODE_ABS, MODE_ABSX, MODE_ABSY, MODE_ZP,
      MODE_ZPX, MODE_INDX, MODE_INDY, MODE_IMM, MODE_ABS, MODE_ABSY, MODE_ZP,
      MODE_ZPY, MODE_IMM, MODE_ABS, MODE_ABSX, MODE_ZP, MODE_ZPX};
   logic [2:0] ld_cyc [0:17] = '{3'd2, 3'd4, 3'd4, 3'd4, 3'd3, 3'd4, 3'd6, 3'd5,
      3'd2, 3'd4, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd4, 3'd3, 3'd4};
   mode_type st_mode [0:12] = '{MODE_ABS, MODE_ZP, MODE_ZPX, MODE_ABSX, MODE_ABSY,
      MODE_INDX, MODE_INDY, MODE_ZP, MODE_ZPY, MODE_ABS, MODE_ZP, MODE_ZPX, MODE_ABS};
   logic [2:0] st_cyc [0:12] = '{3'd4, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd3, 3'd4,
      3'd4, 3'd3, 3'd4, 3'd4};
   logic [7:0] flag_mask [0:6] = '{8'h01, 8'h08, 8'h04, 8'h40, 8'h01, 8'h08, 8'h04};

   op_item_type pending_items [$];
   cpu_view_type expected_views [$];
   int unsigned total_items = 0;
   int unsigned accepted = 0;
   int unsigned fail_count = 0;
   bit req_taken = 1'b0;

   // Reading a byte never written is flagged so that the stimulus can store it first.
   function automatic logic [7:0] mem_rd(input logic [15:0] a);
      if (!mem_known[a] && !probe_missed) begin
         probe_missed = 1'b1;
         probe_addr = a;
      end
      return mem_known[a] ? mem_image[a] : 8'h00;
   endfunction

   function automatic void mem_wr(input logic [15:0] a, input logic [7:0] v);
      if (committing) begin
         mem_image[a] = v;
         mem_known[a] = 1'b1;
      end
   endfunction

   function automatic logic [7:0] fetch_byte();
      logic [7:0] v;
      v = mem_rd(pc);
      pc = pc + 16'd1;
      return v;
   endfunction

   function automatic logic [15:0] fetch_word();
      logic [7:0] lo;
      lo = fetch_byte();
      return {fetch_byte(), lo};
   endfunction

   function automatic logic [15:0] zp_ptr(input logic [7:0] p);
      logic [7:0] lo;
      lo = mem_rd({8'h00, p});
      return {mem_rd({8'h00, 8'(p + 8'd1)}), lo};
   endfunction

   function automatic void set_nz(input logic [7:0] v);
      flags = (flags & ~(FlagN | FlagZ)) | (v == 8'h00 ? FlagZ : 8'h00) | (v & FlagN);
   endfunction

   function automatic void push_byte(input logic [7:0] v);
      mem_wr({StackPage, sp}, v);
      sp = sp - 8'd1;
   endfunction

   function automatic logic [7:0] pull_byte();
      sp = sp + 8'd1;
      return mem_rd({StackPage, sp});
   endfunction

   function automatic logic [15:0] operand_addr(input mode_type m, input bit penalty);
      logic [15:0] base, a;
      case (m)
         MODE_IMM: begin
            a = pc;
            void'(fetch_byte());
         end
         MODE_ZP: a = {8'h00, fetch_byte()};
         MODE_ZPX: a = {8'h00, 8'(fetch_byte() + xr)};
         MODE_ZPY: a = {8'h00, 8'(fetch_byte() + yr)};
         MODE_ABS: a = fetch_word();
         MODE_ABSX, MODE_ABSY: begin
            base = fetch_word();
            a = base + {8'h00, (m == MODE_ABSX) ? xr : yr};
            if (penalty && base[15:8] != a[15:8]) op_cyc = op_cyc + 3'd1;
         end
         MODE_INDX: a = zp_ptr(8'(fetch_byte() + xr));
         default: begin
            base = zp_ptr(fetch_byte());
            a = base + {8'h00, yr};
            if (penalty && base[15:8] != a[15:8]) op_cyc = op_cyc + 3'd1;
         end
      endcase
      return a;
   endfunction

   // Runs one item on the predicted state; without commit every change is undone.
   function automatic cpu_view_type run_op(input op_item_type op, input bit commit);
      logic [7:0] s_acc, s_xr, s_yr, s_sp, s_flags, v, lo, hi, rdata;
      logic [15:0] s_pc, a;
      cpu_view_type r;
      s_acc = acc; s_xr = xr; s_yr = yr; s_sp = sp; s_flags = flags; s_pc = pc;
      committing = commit;
      probe_missed = 1'b0;
      op_cyc = 3'd0;
      rdata = 8'h00;
      if (op.func <= OP_LDY_ZPX) begin
         op_cyc = ld_cyc[op.func];
         v = mem_rd(operand_addr(ld_mode[op.func], 1'b1));
         if (op.func <= OP_LDA_INDY) acc = v;
         else if (op.func <= OP_LDX_ZPY) xr = v;
         else yr = v;
         set_nz(v);
      end else if (op.func <= OP_STY_ABS) begin
         op_cyc = st_cyc[op.func - OP_STA_ABS];
         v = (op.func <= OP_STA_INDY) ? acc : ((op.func <= OP_STX_ABS) ? xr : yr);
         mem_wr(operand_addr(st_mode[op.func - OP_STA_ABS], 1'b0), v);
      end else if (op.func >= OP_CLC && op.func <= OP_SEI) begin
         op_cyc = 3'd2;
         if (op.func <= OP_CLV) flags = flags & ~flag_mask[op.func - OP_CLC];
         else flags = flags | flag_mask[op.func - OP_CLC];
      end else begin
         case (op.func)
            OP_TAX: begin xr = acc; set_nz(xr); op_cyc = 3'd2; end
            OP_TAY: begin yr = acc; set_nz(yr); op_cyc = 3'd2; end
            OP_TXA: begin acc = xr; set_nz(acc); op_cyc = 3'd2; end
            OP_TYA: begin acc = yr; set_nz(acc); op_cyc = 3'd2; end
            OP_PHA: begin push_byte(acc); op_cyc = 3'd3; end
            OP_PLA: begin acc = pull_byte(); set_nz(acc); op_cyc = 3'd4; end
            OP_JMP_ABS: begin pc = fetch_word(); op_cyc = 3'd3; end
            OP_JMP_IND: begin
               // The vector's high byte never leaves the vector's page.
               a = fetch_word();
               lo = mem_rd(a);
               hi = mem_rd({a[15:8], 8'(a[7:0] + 8'd1)});
               pc = {hi, lo};
               op_cyc = 3'd5;
            end
            OP_JSR: begin
               a = fetch_word();
               push_byte(pc[15:8]);
               push_byte(pc[7:0]);
               pc = a;
               op_cyc = 3'd6;
            end
            OP_RTS: begin
               lo = pull_byte();
               hi = pull_byte();
               pc = {hi, lo};
               op_cyc = 3'd6;
            end
            OP_BEQ: begin
               v = fetch_byte();
               op_cyc = 3'd2;
               if ((flags & FlagZ) != 8'h00) begin
                  a = pc + {{8{v[7]}}, v};
                  op_cyc = (a[15:8] != pc[15:8]) ? 3'd4 : 3'd3;
                  pc = a;
               end
            end
            OP_BRK: begin
               lo = mem_rd(VecLo);
               hi = mem_rd(VecHi);
               push_byte(pc[15:8]);
               push_byte(pc[7:0]);
               push_byte(flags);
               pc = {hi, lo};
               flags = flags | FlagB;
               op_cyc = 3'd7;
            end
            OP_NOP: op_cyc = 3'd2;
            OP_RTI: begin
               flags = pull_byte();
               lo = pull_byte();
               hi = pull_byte();
               pc = {hi, lo};
               op_cyc = 3'd6;
            end
            OP_HOST_WR: mem_wr(op.host_addr, op.host_data);
            OP_HOST_RD: rdata = mem_rd(op.host_addr);
            default: ;
         endcase
      end
      r = '{acc, xr, yr, sp, pc, flags, op_cyc, rdata};
      if (!commit) begin
         acc = s_acc; xr = s_xr; yr = s_yr; sp = s_sp; flags = s_flags; pc = s_pc;
      end
      return r;
   endfunction

   // Biased towards zero and sign-bit values so that Z and N turn over often.
   function automatic logic [7:0] data_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h80;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void queue_item(input op_item_type op);
      expected_views.push_back(run_op(op, 1'b1));
      pending_items.push_back(op);
      total_items++;
   endfunction

   // Any byte the operation would read before it is written is stored by a host write first.
   function automatic void issue(input logic [5:0] f, input logic [15:0] ha,
                                 input logic [7:0] hd);
      op_item_type op;
      op = '{f, ha, hd};
      void'(run_op(op, 1'b0));
      while (probe_missed) begin
         queue_item('{OP_HOST_WR, probe_addr, data_byte()});
         void'(run_op(op, 1'b0));
      end
      queue_item(op);
   endfunction

   function automatic void issue_random();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 4) issue(6'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                          16'($urandom), 8'($urandom));
      else if (pick < 10) issue(OP_HOST_RD, ($urandom_range(1) != 0) ? pc : 16'($urandom),
                                8'($urandom));
      else if (pick < 16) issue(OP_HOST_WR, 16'($urandom), data_byte());
      else issue(6'($urandom_range(OP_LDA_IMM, OP_RTI)), 16'($urandom), 8'($urandom));
   endfunction

   function automatic void check_field(input string name, input logic [15:0] exp_v,
                                       input logic [15:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, got_v);
         fail_count++;
      end
   endfunction

   function automatic int unsigned sender_idle_pct();
      if (accepted < total_items / 3) return 36;
      if (accepted < 2 * total_items / 3) return 79;
      return 0;
   endfunction

   function automatic int unsigned receiver_idle_pct();
      if (accepted < total_items / 3) return 79;
      if (accepted < 2 * total_items / 3) return 36;
      return 0;
   endfunction

   always @(negedge clock) begin
      op_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
         if (!req_valid || req_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               nxt = pending_items.pop_front();
               req_valid <= 1'b1;
               req_func <= nxt.func;
               req_host_addr <= nxt.host_addr;
               req_host_data <= nxt.host_data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      cpu_view_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) accepted <= accepted + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_views.size() == 0) begin
            $error("result item arrived with none expected");
            fail_count++;
         end else begin
            want = expected_views.pop_front();
            check_field("reg_a", want.reg_a, rsp_reg_a);
            check_field("reg_x", want.reg_x, rsp_reg_x);
            check_field("reg_y", want.reg_y, rsp_reg_y);
            check_field("stack_ptr", want.stack_ptr, rsp_stack_ptr);
            check_field("prog_counter", want.prog_counter, rsp_prog_counter);
            check_field("status_flags", want.status_flags, rsp_status_flags);
            check_field("cycles", want.cycles, rsp_cycles);
            check_field("read_data", want.read_data, rsp_read_data);
         end
      end
   end

   int unsigned cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("[mos6502_subset_executor_top] ERROR");
         $finish;
      end
   end

   initial begin
      acc = 8'h00; xr = 8'h00; yr = 8'h00; sp = SpReset; pc = 16'h0000; flags = 8'h00;
      for (int i = 0; i < 65536; i++) mem_known[i] = 1'b0;

      // Directed part: a taken BEQ crossing backwards over the address wrap, JMP
      // indirect with its vector on a page end, BRK/RTI and the address extremes.
      issue(OP_HOST_WR, 16'h0000, 8'h00);
      issue(OP_LDA_IMM, 16'hFFFF, 8'hFF);
      issue(OP_HOST_WR, 16'h0001, 8'h80);
      issue(OP_BEQ, 16'h0000, 8'h00);
      issue(OP_HOST_WR, 16'hFF82, 8'hFF);
      issue(OP_HOST_WR, 16'hFF83, 8'h12);
      issue(OP_JMP_IND, 16'h0000, 8'h00);
      issue(OP_HOST_WR, VecLo, 8'hF0);
      issue(OP_HOST_WR, VecHi, 8'hFF);
      issue(OP_BRK, 16'h0000, 8'h00);
      issue(OP_RTI, 16'h0000, 8'h00);
      issue(OP_JSR, 16'h0000, 8'h00);
      issue(OP_RTS, 16'h0000, 8'h00);
      issue(OP_PHA, 16'h0000, 8'h00);
      issue(OP_PLA, 16'h0000, 8'h00);
      issue(OP_SEC, 16'h0000, 8'h00);
      issue(OP_SED, 16'h0000, 8'h00);
      issue(OP_SEI, 16'h0000, 8'h00);
      issue(OP_CLV, 16'h0000, 8'h00);
      issue(OP_HOST_RD, 16'hFFFF, 8'h00);
      issue(OP_UNUSED_LAST, 16'hFFFF, 8'hFF);
      // The host writes that fill unread bytes count towards the total.
      while (total_items < RandomItems) issue_random();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (accepted == total_items && expected_views.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("[mos6502_subset_executor_top] OK");
      end else begin
         $display("[mos6502_subset_executor_top] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
